/* hw/rtl/fkg_pkg.sv */
// Package for the fractional knapsack greedy unit: types, sizes, state codes.
// No dependencies.
package fkg_pkg;
  localparam int MaxItems = 16;
  localparam int IdxW     = $clog2(MaxItems);
  localparam int CntW     = IdxW + 1;
  localparam int CapW     = 22;
  localparam int TotW     = 38;
  localparam logic [16:0] QOne = 17'h10000;

  typedef struct packed {
    logic [15:0] item_profit;
    logic [15:0] item_weight;
    logic        last_item;
  } fkg_in_t;

  typedef struct packed {
    logic [5:0]      load_index;
    logic [15:0]     out_profit;
    logic [15:0]     out_weight;
    logic [16:0]     fraction;
    logic [TotW-1:0] total_profit;
    logic            last_result;
  } fkg_out_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SI, ST_SRD, ST_SIT, ST_SCMP, ST_SWR, ST_ERD, ST_EDAT, ST_EMUL,
    ST_DIV, ST_DMUL, ST_EOUT
  } fkg_state_t;
endpackage

/* hw/rtl/fractional_knapsack_greedy_unit.sv */
// Fractional knapsack greedy unit, top level.
// Depends on fkg_pkg.
//
//  channel | ports                   | handshake
//  in      | in_data (fkg_in_t)      | start & !busy
//  out     | out_data (fkg_out_t)    | out_valid, one cycle, no stall
//  cfg     | cfg_we, cfg_capacity    | cfg_we
//
// Loading accepts one word per cycle. After the last word the block runs a
// stable insertion sort over an order memory (order read, item read, compare,
// write back per inner step, n^2 worst case), then emits: whole items pass
// item read, data, multiply and output, and the split item adds the
// bit-serial restoring divider and the partial product. busy is high from
// the last word until the last result, and drops as that result is on the ports.
// Reset is synchronous; the item memories are not cleared.
module fractional_knapsack_greedy_unit
  import fkg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  fkg_in_t         in_data,
  input  logic            cfg_we,
  input  logic [CapW-1:0] cfg_capacity,
  output logic            out_valid,
  output fkg_out_t        out_data
);
  // item memory {profit,weight}; order memory holds load positions
  logic [31:0]     item_mem [MaxItems];
  logic [IdxW-1:0] ord_mem  [MaxItems];

  fkg_state_t state_r, state_nxt;
  logic [CapW-1:0] cap_r, rem_r;
  logic [CntW-1:0] cnt_r, i_r, j_r;
  logic [TotW-1:0] acc_r;
  logic            split_r;
  logic [31:0]     cur_r, rd_item_r;     // current sort item, item read data
  logic [IdxW-1:0] rd_ord_r, cur_ix_r;
  logic [31:0]     lhs_r, rhs_r;
  logic [16:0]     frac_r;
  logic [38:0]     rem_div_r;            // divider partial remainder
  logic [4:0]      dcnt_r;

  // memory port control
  logic            im_we;  logic [IdxW-1:0] im_wa, im_ra; logic [31:0] im_wd;
  logic            om_we;  logic [IdxW-1:0] om_wa, om_ra, om_wd;

  always_ff @(posedge clk) begin
    if (im_we) item_mem[im_wa] <= im_wd;
    rd_item_r <= item_mem[im_ra];
    if (om_we) ord_mem[om_wa] <= om_wd;
    rd_ord_r <= ord_mem[om_ra];
  end

  logic accept;
  assign busy   = (state_r != ST_LOAD);
  assign accept = start && !busy;

  logic [15:0] rp, rw;
  assign rp = rd_item_r[31:16];
  assign rw = rd_item_r[15:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (accept && in_data.last_item) state_nxt = ST_SI;
      ST_SI:   state_nxt = (i_r == cnt_r) ? ST_ERD : ST_SRD;
      ST_SRD:  state_nxt = (j_r == '0) ? ST_SWR : ST_SIT;
      ST_SIT:  state_nxt = ST_SCMP;
      ST_SCMP: state_nxt = ST_SWR;
      ST_SWR:  state_nxt = (j_r != '0 && lhs_r > rhs_r) ? ST_SRD : ST_SI;
      ST_ERD:  state_nxt = ST_EDAT;
      ST_EDAT: state_nxt = ST_EMUL;
      ST_EMUL: state_nxt = (!split_r && {6'd0, rw} > rem_r) ? ST_DIV : ST_EOUT;
      ST_DIV:  if (dcnt_r == 5'd16) state_nxt = ST_DMUL;
      ST_DMUL: state_nxt = ST_EOUT;
      ST_EOUT: state_nxt = (i_r + 1'b1 == cnt_r) ? ST_LOAD : ST_ERD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // memory addressing
  always_comb begin
    im_we = 1'b0; im_wa = cnt_r[IdxW-1:0];
    im_wd = {in_data.item_profit, in_data.item_weight};
    om_we = 1'b0; om_wa = j_r[IdxW-1:0]; om_wd = cur_ix_r;
    om_ra = i_r[IdxW-1:0];
    im_ra = rd_ord_r;
    unique case (state_r) inside
      ST_LOAD: im_we = accept && (cnt_r != CntW'(MaxItems));
      ST_SI:   begin im_ra = i_r[IdxW-1:0]; end
      // hold the entry below j until it has been written back one place up
      ST_SRD, ST_SIT, ST_SCMP: om_ra = j_r[IdxW-1:0] - 1'b1;
      ST_SWR:  begin
        om_we = 1'b1;
        om_wd = (j_r != '0 && lhs_r > rhs_r) ? rd_ord_r : cur_ix_r;
      end
      default: ;
    endcase
  end

  logic [38:0] dtrial;
  assign dtrial = {rem_div_r[37:0], 1'b0} - {23'd0, rw};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; cap_r <= '0; rem_r <= '0; acc_r <= '0;
      cnt_r <= '0; i_r <= '0; j_r <= '0; split_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) cap_r <= cfg_capacity;
      unique case (state_r)
        ST_LOAD: if (accept) begin
          if (cnt_r != CntW'(MaxItems)) cnt_r <= cnt_r + 1'b1;
          i_r <= '0;
        end
        ST_SI: begin
          j_r <= i_r; cur_ix_r <= i_r[IdxW-1:0];
          if (i_r == cnt_r) begin
            i_r <= '0; rem_r <= cap_r; acc_r <= '0; split_r <= 1'b0;
          end
        end
        ST_SRD: if (i_r == j_r) cur_r <= rd_item_r;
        ST_SCMP: begin
          // rd_ord_r is the order entry below j; rd_item_r its item
          lhs_r <= 32'(cur_r[31:16]) * 32'(rw);
          rhs_r <= 32'(rp) * 32'(cur_r[15:0]);
        end
        ST_SWR: begin
          if (j_r != '0 && lhs_r > rhs_r) j_r <= j_r - 1'b1;
          else i_r <= i_r + 1'b1;
          lhs_r <= '0; rhs_r <= '0;
        end
        ST_EMUL: begin
          if (split_r) frac_r <= '0;
          else if ({6'd0, rw} <= rem_r) begin
            frac_r <= QOne; rem_r <= rem_r - {6'd0, rw};
            acc_r  <= acc_r + {6'd0, rp, 16'd0};
          end else begin
            rem_div_r <= {17'd0, rem_r}; dcnt_r <= '0; frac_r <= '0;
          end
        end
        ST_DIV: begin
          // restoring division of rem<<16 by weight, one bit per cycle
          if (dcnt_r < 5'd16) begin
            if (!dtrial[38]) begin
              rem_div_r <= dtrial; frac_r <= {frac_r[15:0], 1'b1};
            end else begin
              rem_div_r <= {rem_div_r[37:0], 1'b0}; frac_r <= {frac_r[15:0], 1'b0};
            end
          end
          dcnt_r <= dcnt_r + 1'b1;
        end
        ST_DMUL: begin
          acc_r <= acc_r + {6'd0, 32'(rp) * 32'(frac_r[15:0])};
          rem_r <= '0; split_r <= 1'b1;
        end
        ST_EOUT: begin
          out_valid <= 1'b1;
          out_data.load_index   <= 6'(rd_ord_r);
          out_data.out_profit   <= rp;
          out_data.out_weight   <= rw;
          out_data.fraction     <= frac_r;
          out_data.total_profit <= acc_r;
          out_data.last_result  <= (i_r + 1'b1 == cnt_r);
          i_r <= i_r + 1'b1;
          if (i_r + 1'b1 == cnt_r) cnt_r <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

/* hw/rtl/fkg_checker.sv */
// Port-level checker for the fractional knapsack greedy unit, with its bind.
// Depends on fkg_pkg.
module fkg_checker
  import fkg_pkg::*;
(
  input logic clk, input logic rst_n, input logic start, input logic busy,
  input logic out_valid, input fkg_out_t out_data
);
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result while idle");
  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fraction <= QOne) else $error("fraction above one");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !$past(busy)) |=> !out_valid) else $error("spurious result");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result words back to back");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_data.last_result))
    else $error("busy dropped without final result");
endmodule

bind fractional_knapsack_greedy_unit fkg_checker u_fkg_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);

/* bench/fractional_knapsack_greedy_unit_tb.sv */
// Self-checking bench for fractional_knapsack_greedy_unit: drives item batches,
// predicts the greedy fill per batch and checks every result word. Needs fkg_pkg.
module fractional_knapsack_greedy_unit_tb;
  import fkg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  fkg_in_t         in_data = '0;
  logic            cfg_we = 1'b0;
  logic [CapW-1:0] cfg_capacity = '0;
  logic            out_valid;
  fkg_out_t        out_data;

  fractional_knapsack_greedy_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_capacity(cfg_capacity), .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pending words for the driver; the predictor's own copy of the block state
  fkg_in_t         item_q[$];
  fkg_out_t        fill_q[$];
  logic [CapW-1:0] knap_cap;
  logic [15:0]     batch_profit[MaxItems];
  logic [15:0]     batch_weight[MaxItems];
  int              batch_len;
  int              err_count;
  int              word_count;
  int              result_count;
  int              batch_count;
  int              idle_cycles;
  bit              bench_done;
  bit              sender_hold;

  // Greedy fill of the batch closed by a last word: stable sort by ratio
  // (cross products, so no division), then whole items, at most one split, zeros.
  function automatic void predict_fill();
    int          order[MaxItems];
    int          i;
    int          j;
    int          cur;
    logic [21:0] room;
    logic [37:0] total;
    logic [16:0] frac;
    bit          split;
    fkg_out_t    r;
    room  = knap_cap;
    total = '0;
    split = 1'b0;
    for (i = 0; i < batch_len; i++) begin
      cur = i;
      j = i;
      while (j > 0 && (64'(batch_profit[cur]) * batch_weight[order[j-1]] >
                       64'(batch_profit[order[j-1]]) * batch_weight[cur])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (i = 0; i < batch_len; i++) begin
      cur = order[i];
      if (split) begin
        frac = '0;
      end else if (22'(batch_weight[cur]) <= room) begin
        frac  = QOne;
        room  = room - 22'(batch_weight[cur]);
        total = total + (38'(batch_profit[cur]) << 16);
      end else begin
        frac  = 17'((64'(room) << 16) / batch_weight[cur]);
        total = total + 38'(batch_profit[cur]) * frac;
        room  = '0;
        split = 1'b1;
      end
      r.load_index   = 6'(cur);
      r.out_profit   = batch_profit[cur];
      r.out_weight   = batch_weight[cur];
      r.fraction     = frac;
      r.total_profit = total;
      r.last_result  = (i == batch_len - 1);
      fill_q.push_back(r);
    end
    batch_len = 0;
    batch_count++;
  endfunction

  // Driver: per word a random gap, then start until accepted.
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        // word taken at this edge: store it as the block does, overflow dropped
        if (batch_len < MaxItems) begin
          batch_profit[batch_len] = in_data.item_profit;
          batch_weight[batch_len] = in_data.item_weight;
          batch_len++;
        end
        if (in_data.last_item) predict_fill();
        word_count++;
        void'(item_q.pop_front());
        gap_left <= $urandom_range(0, 14) * $urandom_range(0, 1);
        start <= 1'b0;
      end else if (!start && !sender_hold && item_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          in_data <= item_q[0];
          start   <= 1'b1;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so compare each strobed word at once.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      result_count++;
      if (fill_q.size() == 0) begin
        $error("unexpected result word index=%0d", out_data.load_index);
        err_count++;
      end else begin
        fkg_out_t e;
        e = fill_q.pop_front();
        if (out_data.load_index !== e.load_index) begin
          $error("load_index exp %0d got %0d", e.load_index, out_data.load_index);
          err_count++;
        end
        if (out_data.out_profit !== e.out_profit) begin
          $error("out_profit exp %0d got %0d", e.out_profit, out_data.out_profit);
          err_count++;
        end
        if (out_data.out_weight !== e.out_weight) begin
          $error("out_weight exp %0d got %0d", e.out_weight, out_data.out_weight);
          err_count++;
        end
        if (out_data.fraction !== e.fraction) begin
          $error("fraction exp %0d got %0d", e.fraction, out_data.fraction);
          err_count++;
        end
        if (out_data.total_profit !== e.total_profit) begin
          $error("total_profit exp %0d got %0d", e.total_profit,
                 out_data.total_profit);
          err_count++;
        end
        if (out_data.last_result !== e.last_result) begin
          $error("last_result exp %0d got %0d", e.last_result, out_data.last_result);
          err_count++;
        end
      end
    end
  end

  // Watchdog: cycles with nothing accepted on either side. A full batch sorts
  // and drains well within the limit, so the limit is well clear of any stall.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (!bench_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
        $display("watchdog: %0d words pending, %0d results owed", item_q.size(),
                 fill_q.size());
        $display("fractional_knapsack_greedy_unit_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic fkg_in_t make_word(logic [15:0] p, logic [15:0] w, bit last);
    fkg_in_t x;
    x.item_profit = p;
    x.item_weight = (w == 0) ? 16'd1 : w;
    x.last_item   = last;
    return x;
  endfunction

  // Random batch of n words; sizes used are mostly small, occasionally near full, full or overflowing.
  task automatic queue_batch(int n);
    int          k;
    logic [15:0] p;
    logic [15:0] w;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: begin p = 16'($urandom); w = 16'($urandom); end
        1: begin p = 16'($urandom_range(0, 40)); w = 16'($urandom_range(1, 40)); end
        2: begin p = 16'($urandom_range(1, 4) * 100); w = 16'($urandom_range(1, 4) * 50); end
        default: begin p = 16'($urandom_range(60000, 65535)); w = 16'($urandom); end
      endcase
      item_q.push_back(make_word(p, w, k == n - 1));
    end
  endtask

  // Wait for every owed result and for busy to drop, then a settling margin before touching cfg.
  task automatic wait_quiet();
    while (item_q.size() > 0 || start || fill_q.size() > 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CapW-1:0] v);
    wait_quiet();
    cfg_capacity <= v;
    cfg_we       <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    knap_cap = v;
  endtask

  initial begin
    int ph;
    int b;
    int n;
    err_count = 0; word_count = 0; result_count = 0; batch_count = 0;
    batch_len = 0; idle_cycles = 0; bench_done = 0; sender_hold = 0;
    knap_cap = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity of zero: every item gets fraction 0, the first as the split
    item_q.push_back(make_word(16'd5, 16'd3, 1'b0));
    item_q.push_back(make_word(16'hFFFF, 16'hFFFF, 1'b1));
    write_capacity(22'd100);
    // extremes, ties kept in load order, exact fit, single item batch
    item_q.push_back(make_word(16'd0, 16'd1, 1'b0));
    item_q.push_back(make_word(16'd10, 16'd20, 1'b0));
    item_q.push_back(make_word(16'd20, 16'd40, 1'b0));
    item_q.push_back(make_word(16'hFFFF, 16'd1, 1'b0));
    item_q.push_back(make_word(16'd30, 16'd39, 1'b1));
    item_q.push_back(make_word(16'd7, 16'd100, 1'b1));
    item_q.push_back(make_word(16'hAAAA, 16'h5555, 1'b1));
    // overflow: 18 words, the two past the store limit are dropped
    for (n = 0; n < 18; n++)
      item_q.push_back(make_word(16'(n * 37 + 1), 16'(n * 13 + 2), n == 17));

    // wait until the block has drained completely, then raise and drop sender_hold
    wait_quiet();
    sender_hold = 1;
    repeat (5) @(posedge clk);
    sender_hold = 0;

    // random phases across capacity settings including both extremes
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_capacity('1);
        1: write_capacity('0);
        2: write_capacity(22'd1);
        default: write_capacity(CapW'($urandom_range(1, 200000)));
      endcase
      for (b = 0; b < 14; b++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
        queue_batch(n);
      end
    end

    wait_quiet();
    bench_done = 1;
    $display("covered %0d words in %0d batches, %0d result words checked",
             word_count, batch_count, result_count);
    if (err_count == 0) begin
      $display("fractional_knapsack_greedy_unit_tb: done, clean");
    end else begin
      $display("fractional_knapsack_greedy_unit_tb: done, errors");
    end
    $finish;
  end
endmodule

/* files.f */
hw/rtl/fkg_pkg.sv
hw/rtl/fractional_knapsack_greedy_unit.sv
hw/rtl/fkg_checker.sv
bench/fractional_knapsack_greedy_unit_tb.sv
